@@ hw/rtl/bsp_tile_layout_core_assert.svh @@
// Assertion macros shared by the tile layout RTL.
`ifndef BSP_TILE_LAYOUT_CORE_ASSERT_SVH
`define BSP_TILE_LAYOUT_CORE_ASSERT_SVH

// Checked on every rising edge while the block is out of reset.
`define BSPTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BSPTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/bsptl_pkg.sv @@
// Shared types and constants for the tile layout block.
package bsptl_pkg;

  localparam int unsigned MaxWindowsDef   = 64;
  localparam int unsigned ResultLimit     = 64;
  localparam int unsigned PadFallbackSize = 50;

  localparam int unsigned IdxW   = 6;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DimW   = 15;
  localparam int unsigned PadW   = 10;
  localparam int unsigned MinW   = 12;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAreaX   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAreaY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAreaW   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAreaH   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPad     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMinSize = 3'd5;

  typedef struct packed {
    logic [CoordW-1:0] area_x;
    logic [CoordW-1:0] area_y;
    logic [DimW-1:0]   area_w;
    logic [DimW-1:0]   area_h;
    logic [PadW-1:0]   pad;
    logic [MinW-1:0]   min_tile;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } walk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DimW-1:0]   w;
    logic [DimW-1:0]   h;
  } tile_t;

endpackage

@@ hw/rtl/bsptl_walker.sv @@
// Sequencer that walks the partition tree for one tile, one level per cycle.
module bsptl_walker #(
  parameter int unsigned MaxWindows  = bsptl_pkg::MaxWindowsDef,
  parameter int unsigned PadFallback = bsptl_pkg::PadFallbackSize,
  localparam int unsigned Limit =
    (MaxWindows < bsptl_pkg::ResultLimit) ? MaxWindows : bsptl_pkg::ResultLimit,
  localparam int unsigned CntW = $clog2(Limit + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bsptl_pkg::cfg_t                cfg_i,
  input  bsptl_pkg::walk_ctrl_t          ctrl_i,
  input  logic [bsptl_pkg::IdxW-1:0]     idx_i,
  input  logic [CntW-1:0]                count_i,
  output bsptl_pkg::walk_stat_t          stat_o,
  output bsptl_pkg::tile_t               tile_o
);
  import bsptl_pkg::*;

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_SPLIT = 2'd1;
  localparam logic [1:0] W_PAD   = 2'd2;
  localparam logic [1:0] W_MIN   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              done_q, done_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d;
  logic [DimW-1:0]   w_q, w_d, h_q, h_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   base_q, base_d;
  logic              odd_q, odd_d;

  logic [CntW-1:0]   first;
  logic [CntW-1:0]   cnt_next;
  logic [IdxW:0]     split_at;
  logic              go_first;
  logic [DimW-1:0]   half_w, half_h;
  logic [PadW:0]     pad2;
  logic [DimW-1:0]   pad2_ext, min_ext;

  assign first    = cnt_q >> 1;
  assign split_at = {1'b0, base_q} + (IdxW+1)'(first);
  assign go_first = {1'b0, idx_i} < split_at;
  assign cnt_next = go_first ? first : cnt_q - first;
  assign half_w   = w_q >> 1;
  assign half_h   = h_q >> 1;
  assign pad2     = {cfg_i.pad, 1'b0};
  assign pad2_ext = DimW'(pad2);
  assign min_ext  = DimW'(cfg_i.min_tile);

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    x_d     = x_q;
    y_d     = y_q;
    w_d     = w_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    odd_d   = odd_q;
    case (state_q)
      W_IDLE: begin
        if (done_q && ctrl_i.ack) begin
          done_d = 1'b0;
        end
        if (ctrl_i.start) begin
          x_d     = cfg_i.area_x;
          y_d     = cfg_i.area_y;
          w_d     = cfg_i.area_w;
          h_d     = cfg_i.area_h;
          cnt_d   = count_i;
          base_d  = '0;
          odd_d   = 1'b0;
          done_d  = 1'b0;
          state_d = (count_i > CntW'(1)) ? W_SPLIT : W_PAD;
        end
      end
      W_SPLIT: begin
        // Even levels cut the width, odd levels cut the height.
        if (!odd_q) begin
          if (go_first) begin
            w_d = half_w;
          end else begin
            x_d = x_q + CoordW'(half_w);
            w_d = w_q - half_w;
          end
        end else begin
          if (go_first) begin
            h_d = half_h;
          end else begin
            y_d = y_q + CoordW'(half_h);
            h_d = h_q - half_h;
          end
        end
        if (!go_first) begin
          base_d = base_q + IdxW'(first);
        end
        cnt_d = cnt_next;
        odd_d = !odd_q;
        if (cnt_next == CntW'(1)) begin
          state_d = W_PAD;
        end
      end
      W_PAD: begin
        // An empty leaf keeps its place and size; only the minimum applies.
        if (w_q != '0 && h_q != '0) begin
          x_d = x_q + CoordW'(cfg_i.pad);
          y_d = y_q + CoordW'(cfg_i.pad);
          w_d = (w_q > pad2_ext) ? w_q - pad2_ext : DimW'(PadFallback);
          h_d = (h_q > pad2_ext) ? h_q - pad2_ext : DimW'(PadFallback);
        end
        state_d = W_MIN;
      end
      W_MIN: begin
        if (w_q < min_ext) begin
          w_d = min_ext;
        end
        if (h_q < min_ext) begin
          h_d = min_ext;
        end
        done_d  = 1'b1;
        state_d = W_IDLE;
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    w_q    <= w_d;
    h_q    <= h_d;
    cnt_q  <= cnt_d;
    base_q <= base_d;
    odd_q  <= odd_d;
  end

  assign stat_o.busy = (state_q != W_IDLE) || done_q;
  assign stat_o.done = done_q;
  assign tile_o.x    = x_q;
  assign tile_o.y    = y_q;
  assign tile_o.w    = w_q;
  assign tile_o.h    = h_q;

endmodule

@@ hw/rtl/bsp_tile_layout_core.sv @@
// BSP tile layout core. An input item carries a window count n; the block
// answers with n tile rectangles in window order, tlast set on the final one,
// and a count of zero gives no tiles at all. The count is saturated to the
// smaller of MAX_WINDOWS and 64. The configured workspace is split in halves
// recursively, side by side at even depths and stacked at odd depths, the
// first floor(n/2) windows taking the first floor(extent/2) pixels. Each
// non-empty leaf is then padded on every side (a dimension too small for
// the padding falls back to PAD_FALLBACK_SIZE) and every tile is raised to
// the minimum size. Tiles are computed one at a time by a single walker
// that descends one tree level per cycle: a tile passes through a load
// step, one split step per level (floor(log2 n) to ceil(log2 n) levels),
// a pad step, a minimum step and a hand-off to the output register, which
// waits while the sink holds a tile back. The input side is ready only
// while no layout is in progress. Configuration writes are always accepted
// and must only be issued while the block is idle.
`include "bsp_tile_layout_core_assert.svh"

module bsp_tile_layout_core #(
  parameter int unsigned MAX_WINDOWS       = bsptl_pkg::MaxWindowsDef,
  parameter int unsigned PAD_FALLBACK_SIZE = bsptl_pkg::PadFallbackSize
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bsptl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  // Request stream. tdata: [6:0] window_count, [7] zero.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,
  // Tile stream. tdata: [5:0] tile_index, [21:6] tile_x, [37:22] tile_y,
  // [52:38] tile_width, [67:53] tile_height, [71:68] zero.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [71:0]                       m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import bsptl_pkg::*;

  localparam int unsigned Limit =
    (MAX_WINDOWS < ResultLimit) ? MAX_WINDOWS : ResultLimit;
  localparam int unsigned CntW = $clog2(Limit + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  // Configuration registers.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_x   <= '0;
      cfg_q.area_y   <= '0;
      cfg_q.area_w   <= DimW'(1920);
      cfg_q.area_h   <= DimW'(1080);
      cfg_q.pad      <= '0;
      cfg_q.min_tile <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAreaX:   cfg_q.area_x   <= cfg_data_i[CoordW-1:0];
        CfgAreaY:   cfg_q.area_y   <= cfg_data_i[CoordW-1:0];
        CfgAreaW:   cfg_q.area_w   <= cfg_data_i[DimW-1:0];
        CfgAreaH:   cfg_q.area_h   <= cfg_data_i[DimW-1:0];
        CfgPad:     cfg_q.pad      <= cfg_data_i[PadW-1:0];
        CfgMinSize: cfg_q.min_tile <= cfg_data_i[MinW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request control: the layout state, the saturated count and the tile
  // currently being walked.
  logic             state_q, state_d;
  logic             start_q, start_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [6:0]       win_count;
  logic [CntW-1:0]  count_sat;
  logic             in_take;
  logic             tile_last;

  // Output register; the walker hands over when it is empty or the sink takes the held tile.
  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_idx_q;
  logic             out_last_q;
  tile_t            out_tile_q;

  walk_ctrl_t       walk_ctrl;
  walk_stat_t       walk_stat;
  tile_t            walk_tile;
  logic             hand_off;

  // Helpers for the checks at the end.
  logic             out_take;
  logic [DimW-1:0]  min_floor;
  logic             tile_small;

  assign win_count = s_axis_tdata_i[6:0];
  assign count_sat = (win_count > 7'(Limit)) ? CntW'(Limit) : CntW'(win_count);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign hand_off = walk_stat.done && (!out_valid_q || m_axis_tready_i);
  assign tile_last = ((7'(idx_q) + 7'd1) == 7'(n_q));

  assign walk_ctrl.start = start_q;
  assign walk_ctrl.ack   = hand_off;

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    n_d         = n_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_take && count_sat != '0) begin
          n_d     = count_sat;
          idx_d   = '0;
          start_d = 1'b1;
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (hand_off) begin
          out_valid_d = 1'b1;
          if (tile_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            start_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    idx_q <= idx_d;
    if (hand_off) begin
      out_idx_q  <= idx_q;
      out_last_q <= tile_last;
      out_tile_q <= walk_tile;
    end
  end

  bsptl_walker #(
    .MaxWindows  (MAX_WINDOWS),
    .PadFallback (PAD_FALLBACK_SIZE)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .ctrl_i  (walk_ctrl),
    .idx_i   (idx_q),
    .count_i (n_q),
    .stat_o  (walk_stat),
    .tile_o  (walk_tile)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'b0000, out_tile_q.h, out_tile_q.w,
                            out_tile_q.y, out_tile_q.x, out_idx_q};

  assign out_take   = m_axis_tvalid_o && m_axis_tready_i;
  assign min_floor  = DimW'(cfg_q.min_tile);
  assign tile_small = (out_tile_q.w < min_floor) || (out_tile_q.h < min_floor);

  // The walker never runs while the block waits for a new request.
  `BSPTL_ASSERT(a_idle_walker_quiet, (state_q == S_IDLE) |-> !walk_stat.busy, "walker busy")
  // A tile that is not the last one leaves the layout still in progress.
  `BSPTL_ASSERT(a_tiles_pending, (out_take && !m_axis_tlast_o) |-> (state_q == S_BUSY), "early end")
  // Every delivered tile respects the configured minimum size.
  `BSPTL_ASSERT(a_min_tile_kept, m_axis_tvalid_o |-> !tile_small, "tile below minimum size")
  // No tile is offered while reset is held.
  `BSPTL_ASSERT_ALWAYS(a_no_tile_in_reset, !rst_ni |-> !m_axis_tvalid_o, "tile during reset")

endmodule
